// ----- hdl/mailbox_split_ring_manager_macros.svh -----
// Assertion macros shared by the mailbox ring manager RTL.
`ifndef MAILBOX_SPLIT_RING_MANAGER_MACROS_SVH
`define MAILBOX_SPLIT_RING_MANAGER_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define MSRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define MSRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/msrm_pkg.sv -----
// Package: sizes, codes, sequencer states and modulo unit types for the mailbox ring manager.
package msrm_pkg;

    // Sizing
    localparam int MAX_MAILBOXES = 64;
    localparam int IDX_W         = (MAX_MAILBOXES > 1) ? $clog2(MAX_MAILBOXES) : 1;
    localparam int NUM_W         = $clog2(MAX_MAILBOXES + 1);
    localparam int CNT_W         = 32;
    localparam int TOP_W         = $clog2(CNT_W);
    localparam int MB_W          = 6;
    localparam int CFG_W         = 7;
    localparam int CFG_RESET     = 64;

    // Command codes
    typedef enum logic [1:0] {
        CMD_SEND    = 2'd0,
        CMD_PEEK    = 2'd1,
        CMD_CONSUME = 2'd2,
        CMD_FREE    = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MOD_WAIT,
        S_SEND_WR,
        S_AV_RD,
        S_AV_DATA,
        S_USED_WR,
        S_FREE_RD,
        S_FREE_DATA,
        S_FREE_MARK,
        S_SCAN_INIT,
        S_SCAN,
        S_DONE
    } state_t;

    // Modulo unit request and response
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] dividend;
        logic [TOP_W-1:0] top_bit;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] remainder;
    } mod_rsp_t;

    // Register value to active mailbox count, saturated to 1..MAX_MAILBOXES
    function automatic logic [NUM_W-1:0] sat_count(input logic [CFG_W-1:0] value);
        logic [NUM_W-1:0] n;
        if (value == '0)
            n = NUM_W'(1);
        else if (32'(value) > 32'(MAX_MAILBOXES))
            n = NUM_W'(MAX_MAILBOXES);
        else
            n = NUM_W'(value);
        return n;
    endfunction

endpackage

// ----- hdl/mailbox_split_ring_manager.sv -----
// Top level: mailbox pool manager with idle flags, available ring and used ring.
//
//  channel | handshake             | beat contents
//  --------+-----------------------+------------------------------------------------
//  cmd     | cmd_valid / cmd_ready | command, mailbox_num
//  rsp     | rsp_valid / rsp_ready | status, taken_mailbox, freed_count, idle_found,
//          |                       | idle_mailbox
//  cfg     | cfg_valid / cfg_ready | mailbox_count
//
// One command at a time. Ring slots are counter modulo count, taken by a shared
// one-bit-per-cycle remainder unit. Free marks each released entry idle, first
// reducing an entry not below the count. Every command ends with a scan of the
// idle flags from count-1 down, one flag a cycle. A stalled rsp holds the
// sequencer in its last state until the output register is free.
// cmd_ready is high only between commands; the finished beat sits in an output
// register, so the next command is taken while rsp waits. cfg_ready is always high.
// Reset clears flags to idle, counters to zero, count to 64; ring memories are not
// cleared.
`include "mailbox_split_ring_manager_macros.svh"

module mailbox_split_ring_manager (
    input  logic                        clk,
    input  logic                        rst_n,
    // Command channel
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  logic [1:0]                  command,
    input  logic [msrm_pkg::MB_W-1:0]   mailbox_num,
    // Result channel
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [1:0]                  status,
    output logic [msrm_pkg::MB_W-1:0]   taken_mailbox,
    output logic [msrm_pkg::CNT_W-1:0]  freed_count,
    output logic                        idle_found,
    output logic [msrm_pkg::MB_W-1:0]   idle_mailbox,
    // Configuration channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [msrm_pkg::CFG_W-1:0]  mailbox_count
);
    import msrm_pkg::*;

    // Sequencer and command registers
    state_t               state_reg, state_next;
    state_t               ret_reg, ret_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic [MB_W-1:0]      mb_reg, mb_next;
    logic [NUM_W-1:0]     n_reg, n_next;

    // Pool state
    logic [MAX_MAILBOXES-1:0] idle_flags_reg, idle_flags_next;
    logic [CNT_W-1:0]     avail_cnt_reg, avail_cnt_next;
    logic [CNT_W-1:0]     used_cnt_reg, used_cnt_next;
    logic [CNT_W-1:0]     cons_pos_reg, cons_pos_next;
    logic [CNT_W-1:0]     free_pos_reg, free_pos_next;

    // Work registers
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [NUM_W-1:0]     walk_reg, walk_next;
    logic [IDX_W-1:0]     scan_reg, scan_next;
    status_t              status_reg, status_next;
    logic [MB_W-1:0]      taken_reg, taken_next;
    logic [CNT_W-1:0]     freed_reg, freed_next;

    // Result register
    logic                 rsp_valid_reg, rsp_valid_next;
    status_t              rsp_status_reg, rsp_status_next;
    logic [MB_W-1:0]      rsp_taken_reg, rsp_taken_next;
    logic [CNT_W-1:0]     rsp_freed_reg, rsp_freed_next;
    logic                 rsp_found_reg, rsp_found_next;
    logic [MB_W-1:0]      rsp_idle_reg, rsp_idle_next;

    // Ring memories
    logic [MB_W-1:0]      avail_ring [MAX_MAILBOXES];
    logic [MB_W-1:0]      used_ring [MAX_MAILBOXES];
    logic [MB_W-1:0]      av_rdata_reg;
    logic [MB_W-1:0]      used_rdata_reg;
    logic                 av_we;
    logic                 used_we;

    // Modulo unit
    mod_req_t             mod_req;
    mod_rsp_t             mod_rsp;

    // Helpers
    logic                 cmd_fire;
    logic                 rsp_free;
    logic                 wrap_hit;
    logic [IDX_W-1:0]     idx_inc;

    msrm_mod u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mod_req),
        .divisor (n_reg),
        .rsp     (mod_rsp)
    );

    assign cmd_ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign cfg_ready = 1'b1;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    // Ring pointer advance with wrap at the count
    assign wrap_hit = ((NUM_W'(idx_reg) + NUM_W'(1)) == n_reg);
    assign idx_inc  = wrap_hit ? '0 : IDX_W'(NUM_W'(idx_reg) + NUM_W'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                case (cmd_reg)
                    CMD_SEND:
                        state_next = (32'(mb_reg) >= 32'(n_reg)) ? S_SCAN_INIT : S_MOD_WAIT;
                    CMD_PEEK, CMD_CONSUME:
                        state_next = (avail_cnt_reg == cons_pos_reg) ? S_SCAN_INIT : S_MOD_WAIT;
                    CMD_FREE:
                        state_next = (used_cnt_reg == free_pos_reg) ? S_SCAN_INIT : S_MOD_WAIT;
                    default:
                        state_next = S_SCAN_INIT;
                endcase
            end
            S_MOD_WAIT:
            begin
                if (mod_rsp.done)
                    state_next = ret_reg;
            end
            S_SEND_WR:
                state_next = S_SCAN_INIT;
            S_AV_RD:
                state_next = S_AV_DATA;
            S_AV_DATA:
                state_next = (cmd_reg == CMD_CONSUME) ? S_MOD_WAIT : S_SCAN_INIT;
            S_USED_WR:
                state_next = S_SCAN_INIT;
            S_FREE_RD:
                state_next = S_FREE_DATA;
            S_FREE_DATA:
            begin
                if (32'(used_rdata_reg) >= 32'(n_reg))
                    state_next = S_MOD_WAIT;
                else
                    state_next = (walk_reg == NUM_W'(1)) ? S_SCAN_INIT : S_FREE_RD;
            end
            S_FREE_MARK:
                state_next = (walk_reg == NUM_W'(1)) ? S_SCAN_INIT : S_FREE_RD;
            S_SCAN_INIT:
                state_next = S_SCAN;
            S_SCAN:
            begin
                if (idle_flags_reg[scan_reg] || scan_reg == '0)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs of the sequencer
    always_comb
    begin
        ret_next        = ret_reg;
        cmd_next        = cmd_reg;
        mb_next         = mb_reg;
        n_next          = n_reg;
        idle_flags_next = idle_flags_reg;
        avail_cnt_next  = avail_cnt_reg;
        used_cnt_next   = used_cnt_reg;
        cons_pos_next   = cons_pos_reg;
        free_pos_next   = free_pos_reg;
        idx_next        = idx_reg;
        walk_next       = walk_reg;
        scan_next       = scan_reg;
        status_next     = status_reg;
        taken_next      = taken_reg;
        freed_next      = freed_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_taken_next  = rsp_taken_reg;
        rsp_freed_next  = rsp_freed_reg;
        rsp_found_next  = rsp_found_reg;
        rsp_idle_next   = rsp_idle_reg;
        av_we           = 1'b0;
        used_we         = 1'b0;
        mod_req         = '0;

        if (cfg_valid && cfg_ready)
            n_next = sat_count(mailbox_count);

        if (rsp_ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    cmd_next    = command;
                    mb_next     = mailbox_num;
                    status_next = ST_DONE;
                    taken_next  = '0;
                    freed_next  = '0;
                end
            end
            S_DISPATCH:
            begin
                mod_req.top_bit = TOP_W'(CNT_W - 1);
                case (cmd_reg)
                    CMD_SEND:
                    begin
                        if (32'(mb_reg) >= 32'(n_reg))
                            status_next = ST_RANGE;
                        else
                        begin
                            mod_req.start    = 1'b1;
                            mod_req.dividend = avail_cnt_reg;
                            ret_next         = S_SEND_WR;
                        end
                    end
                    CMD_PEEK, CMD_CONSUME:
                    begin
                        if (avail_cnt_reg == cons_pos_reg)
                            status_next = ST_EMPTY;
                        else
                        begin
                            mod_req.start    = 1'b1;
                            mod_req.dividend = cons_pos_reg;
                            ret_next         = S_AV_RD;
                        end
                    end
                    CMD_FREE:
                    begin
                        if (used_cnt_reg == free_pos_reg)
                            status_next = ST_EMPTY;
                        else
                        begin
                            freed_next       = used_cnt_reg - free_pos_reg;
                            walk_next        = ((used_cnt_reg - free_pos_reg) < 32'(n_reg)) ?
                                               NUM_W'(used_cnt_reg - free_pos_reg) : n_reg;
                            mod_req.start    = 1'b1;
                            mod_req.dividend = free_pos_reg;
                            ret_next         = S_FREE_RD;
                        end
                    end
                    default:
                        status_next = ST_DONE;
                endcase
            end
            S_MOD_WAIT:
            begin
                // Entry remainders are used in place; ring remainders become the slot index
                if (mod_rsp.done && ret_reg != S_FREE_MARK)
                    idx_next = mod_rsp.remainder;
            end
            S_SEND_WR:
            begin
                av_we                               = 1'b1;
                idle_flags_next[IDX_W'(mb_reg)]     = 1'b0;
                avail_cnt_next                      = avail_cnt_reg + CNT_W'(1);
            end
            S_AV_DATA:
            begin
                taken_next = av_rdata_reg;
                if (cmd_reg == CMD_CONSUME)
                begin
                    mod_req.start    = 1'b1;
                    mod_req.dividend = used_cnt_reg;
                    mod_req.top_bit  = TOP_W'(CNT_W - 1);
                    ret_next         = S_USED_WR;
                end
            end
            S_USED_WR:
            begin
                used_we        = 1'b1;
                used_cnt_next  = used_cnt_reg + CNT_W'(1);
                cons_pos_next  = cons_pos_reg + CNT_W'(1);
            end
            S_FREE_DATA:
            begin
                if (32'(used_rdata_reg) >= 32'(n_reg))
                begin
                    // Entry not below the count: reduce it first
                    mod_req.start    = 1'b1;
                    mod_req.dividend = CNT_W'(used_rdata_reg);
                    mod_req.top_bit  = TOP_W'(MB_W - 1);
                    ret_next         = S_FREE_MARK;
                end
                else
                begin
                    idle_flags_next[IDX_W'(used_rdata_reg)] = 1'b1;
                    idx_next  = idx_inc;
                    walk_next = walk_reg - NUM_W'(1);
                    if (walk_reg == NUM_W'(1))
                        free_pos_next = free_pos_reg + freed_reg;
                end
            end
            S_FREE_MARK:
            begin
                idle_flags_next[mod_rsp.remainder] = 1'b1;
                idx_next  = idx_inc;
                walk_next = walk_reg - NUM_W'(1);
                if (walk_reg == NUM_W'(1))
                    free_pos_next = free_pos_reg + freed_reg;
            end
            S_SCAN_INIT:
                scan_next = IDX_W'(n_reg - NUM_W'(1));
            S_SCAN:
            begin
                if (!idle_flags_reg[scan_reg] && scan_reg != '0)
                    scan_next = scan_reg - IDX_W'(1);
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_taken_next  = taken_reg;
                    rsp_freed_next  = freed_reg;
                    rsp_found_next  = idle_flags_reg[scan_reg];
                    rsp_idle_next   = idle_flags_reg[scan_reg] ? MB_W'(scan_reg) : '0;
                end
            end
            default:
                ret_next = ret_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            n_reg          <= sat_count(CFG_W'(CFG_RESET));
            idle_flags_reg <= '1;
            avail_cnt_reg  <= '0;
            used_cnt_reg   <= '0;
            cons_pos_reg   <= '0;
            free_pos_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            n_reg          <= n_next;
            idle_flags_reg <= idle_flags_next;
            avail_cnt_reg  <= avail_cnt_next;
            used_cnt_reg   <= used_cnt_next;
            cons_pos_reg   <= cons_pos_next;
            free_pos_reg   <= free_pos_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload and work registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        mb_reg         <= mb_next;
        idx_reg        <= idx_next;
        walk_reg       <= walk_next;
        scan_reg       <= scan_next;
        status_reg     <= status_next;
        taken_reg      <= taken_next;
        freed_reg      <= freed_next;
        rsp_status_reg <= rsp_status_next;
        rsp_taken_reg  <= rsp_taken_next;
        rsp_freed_reg  <= rsp_freed_next;
        rsp_found_reg  <= rsp_found_next;
        rsp_idle_reg   <= rsp_idle_next;
    end

    // Available ring: one write, one registered read at the slot index
    always_ff @(posedge clk)
    begin
        if (av_we)
            avail_ring[idx_reg] <= mb_reg;
        av_rdata_reg <= avail_ring[idx_reg];
    end

    // Used ring: one write, one registered read at the slot index
    always_ff @(posedge clk)
    begin
        if (used_we)
            used_ring[idx_reg] <= taken_reg;
        used_rdata_reg <= used_ring[idx_reg];
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = rsp_status_reg;
    assign taken_mailbox = rsp_taken_reg;
    assign freed_count   = rsp_freed_reg;
    assign idle_found    = rsp_found_reg;
    assign idle_mailbox  = rsp_idle_reg;

    // Checks
    `MSRM_ASSERT_NEXT(a_busy_after_accept, cmd_fire, !cmd_ready,
        "command accepted but block still ready next cycle")
    `MSRM_ASSERT_NOW(a_mod_done_waited, mod_rsp.done, state_reg == S_MOD_WAIT,
        "remainder finished while the sequencer was not waiting for it")
    `MSRM_ASSERT_NOW(a_range_no_effect,
        rsp_valid && status == ST_RANGE, taken_mailbox == '0 && freed_count == '0,
        "out-of-range send reported a taken mailbox or a freed count")
    `MSRM_ASSERT_NOW(a_freed_only_done, rsp_valid && freed_count != '0, status == ST_DONE,
        "freed count reported with a failing status")
    `MSRM_ASSERT_NOW(a_no_idle_zero, rsp_valid && !idle_found, idle_mailbox == '0,
        "idle mailbox nonzero while no mailbox is idle")

endmodule

// ----- hdl/msrm_mod.sv -----
// Iterative remainder unit: one dividend bit per cycle, restoring, against the active count.
module msrm_mod (
    input  logic                    clk,
    input  logic                    rst_n,
    input  msrm_pkg::mod_req_t      req,
    input  logic [msrm_pkg::NUM_W-1:0] divisor,
    output msrm_pkg::mod_rsp_t      rsp
);
    import msrm_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [TOP_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] dvd_reg, dvd_next;
    logic [IDX_W-1:0] rem_reg, rem_next;

    logic [IDX_W:0]   trial;
    logic [IDX_W:0]   dsr;
    logic [IDX_W-1:0] rem_step;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[idx_reg]};
        dsr      = (IDX_W + 1)'(divisor);
        rem_step = (trial >= dsr) ? IDX_W'(trial - dsr) : IDX_W'(trial);
    end

    // Step control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        idx_next  = idx_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            idx_next  = req.top_bit;
            dvd_next  = req.dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            if (idx_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg - TOP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
        end
    end

    // Operand and partial remainder
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule
